// ----- src/eld_pkg.sv -----
// ----------------------------------------------------------------------------
// eld_pkg
// Shared types, constants and helper functions of the escaped line decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package eld_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_UNICODE_MODE  = 2'd0;
    localparam logic [1:0] CFG_LINE_END_CHAR = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_CHAR   = 2'd2;

    // configuration reset values
    localparam logic [7:0] LINE_END_RESET = 8'd10;
    localparam logic [7:0] ESCAPE_RESET   = 8'd92;

    // character constants
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_SEVEN = 8'd55;
    localparam logic [7:0] CH_U     = 8'd117;
    localparam logic [7:0] CH_X     = 8'd120;
    localparam logic [7:0] HEX_GAP  = 8'd39;
    localparam logic [7:0] CASE_GAP = 8'd32;

    // command queue depth between front and back
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // escape parser phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_OCT  = 3'd2,
        PH_HEX  = 3'd3,
        PH_UNI  = 3'd4
    } t_phase;

    // one queued command: up to three output bytes, sent b0 first
    typedef struct packed {
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
        logic [1:0] cnt;
        logic       eol;
        logic       err;
    } t_cmd;

    // back-to-queue handshake
    typedef struct packed {
        logic pop;
    } t_pop;

    // queue-to-back status
    typedef struct packed {
        logic not_empty;
        t_cmd head;
    } t_head;

    // single data byte command
    function automatic t_cmd f_single(input logic [7:0] b);
        t_cmd c;
        c     = '0;
        c.b0  = b;
        c.cnt = 2'd1;
        return c;
    endfunction

    // value of one hex character, same truncated arithmetic on any byte
    function automatic logic [7:0] f_hex_digit(input logic [7:0] ch);
        logic [7:0] lc;
        logic       alpha;
        lc = ch;
        if (lc >= "A" && lc <= "Z") begin
            lc = lc + CASE_GAP;
        end
        alpha = (lc >= "a" && lc <= "z");
        lc = lc - CH_ZERO;
        if (alpha) begin
            lc = lc - HEX_GAP;
        end
        return lc;
    endfunction

    // two hex characters into one byte, truncated to 8 bits
    function automatic logic [7:0] f_hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        h = f_hex_digit(hi);
        return {h[3:0], 4'b0000} + f_hex_digit(lo);
    endfunction

    // utf-8 encoding of a 16-bit code point
    function automatic t_cmd f_utf8(input logic [15:0] v);
        t_cmd c;
        c = '0;
        if (v < 16'h0080) begin
            c = f_single(v[7:0]);
        end else if (v < 16'h0800) begin
            c.b0  = {3'b110, v[10:6]};
            c.b1  = {2'b10, v[5:0]};
            c.cnt = 2'd2;
        end else begin
            c.b0  = {4'b1110, v[15:12]};
            c.b1  = {2'b10, v[11:6]};
            c.b2  = {2'b10, v[5:0]};
            c.cnt = 2'd3;
        end
        return c;
    endfunction

    // end of an escape: error, utf-8, literal pair or plain byte
    function automatic t_cmd f_finish(input logic [7:0] value, input logic [7:0] letter,
                                      input logic umode, input logic [7:0] esc);
        t_cmd c;
        c = '0;
        if (umode) begin
            if (value == letter) begin
                c.cnt = 2'd1;
                c.err = 1'b1;
            end else begin
                c = f_utf8({8'h00, value});
            end
        end else if (value == letter) begin
            c.b0  = esc;
            c.b1  = letter;
            c.cnt = 2'd2;
        end else begin
            c = f_single(value);
        end
        return c;
    endfunction

    // value of a single-letter escape, the letter itself when unknown
    function automatic logic [7:0] f_letter_value(input logic [7:0] ch);
        logic [7:0] v;
        case (ch)
            "a":     v = 8'd7;
            "b":     v = 8'd8;
            "f":     v = 8'd12;
            "n":     v = 8'd10;
            "r":     v = 8'd13;
            "t":     v = 8'd9;
            "v":     v = 8'd11;
            default: v = ch;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/escaped_line_decoder_core.sv -----
// ----------------------------------------------------------------------------
// escaped_line_decoder_core
// Decodes backslash escapes of a text line, one raw byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries one raw byte per transfer in tdata.
//   Master stream (o_m_*) carries decoded bytes; tuser flags end of line
//   (bit 0) or a rejected escape (bit 1), and tlast marks the final
//   output caused by one input byte. A byte inside an escape that does
//   not finish it gives no output.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//   (0 unicode mode, 1 line end char, 2 escape char); the user must write
//   only while idle, the block does not enforce it. An input byte's command
//   is queued before it reaches the output. Input takes one byte per cycle
//   while the queue has room; a multi-byte UTF-8 or literal pair result goes
//   out one byte per transfer on the single output port and can fill the queue.
//   A four-entry command queue sits between the parser and the output, so
//   input keeps flowing while the receiver stalls until the queue fills;
//   the output holds steady under stall.
//   Synchronous active-low reset empties the queue, returns the parser to
//   idle and loads the register defaults (byte mode, newline, backslash).
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_line_decoder_core
    import eld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    // slave stream
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    // master stream
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic [1:0]      o_m_tuser,   // [0] end_of_line, [1] escape_error
    output logic            o_m_tlast    // last
);

    logic  push;
    logic  room;
    t_cmd  cmd;
    t_pop  pop;
    t_head head;

    eld_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_byte     (i_s_tdata),
        .i_room     (room),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    eld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_room  (room),
        .i_pop   (pop),
        .o_head  (head)
    );

    eld_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser),
        .o_last  (o_m_tlast)
    );

endmodule

`default_nettype wire

// ----- src/eld_front.sv -----
// ----------------------------------------------------------------------------
// eld_front
// Accepts input bytes, runs the escape parser and pushes output commands.
// ----------------------------------------------------------------------------
`default_nettype none

module eld_front
    import eld_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_room,
    output logic            o_push,
    output t_cmd            o_cmd
);

    logic       r_umode;
    logic [7:0] r_eol_char;
    logic [7:0] r_esc_char;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_letter, n_letter;
    logic [7:0]  r_pending, n_pending;
    logic [15:0] r_partial, n_partial;
    logic [1:0]  r_digits, n_digits;

    logic       accept;
    logic       has_cmd;
    t_cmd       cmd;
    logic [7:0] oct_val;
    logic [7:0] pair_val;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_umode    <= 1'b0;
            r_eol_char <= LINE_END_RESET;
            r_esc_char <= ESCAPE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_UNICODE_MODE:  r_umode    <= i_cfg_data[0];
                CFG_LINE_END_CHAR: r_eol_char <= i_cfg_data;
                CFG_ESCAPE_CHAR:   r_esc_char <= i_cfg_data;
                default:           r_umode    <= r_umode;
            endcase
        end
    end

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    assign oct_val  = r_partial[7:0] + i_byte - CH_ZERO;
    assign pair_val = f_hex_pair(r_pending, i_byte);

    // parser next state and command
    always_comb begin
        n_phase   = r_phase;
        n_letter  = r_letter;
        n_pending = r_pending;
        n_partial = r_partial;
        n_digits  = r_digits;
        has_cmd   = 1'b0;
        cmd       = '0;
        case (r_phase)
            PH_ESC: begin
                n_letter  = i_byte;
                n_partial = '0;
                n_digits  = 2'd0;
                n_pending = '0;
                n_phase   = PH_IDLE;
                if (r_umode && i_byte == CH_U) begin
                    n_phase = PH_UNI;
                end else if (i_byte >= CH_ZERO && i_byte <= CH_SEVEN) begin
                    n_partial = {8'h00, i_byte[1:0], 6'b000000};
                    n_digits  = 2'd1;
                    n_phase   = PH_OCT;
                end else if (i_byte == CH_X) begin
                    n_phase = PH_HEX;
                end else begin
                    has_cmd = 1'b1;
                    cmd     = f_finish(f_letter_value(i_byte), i_byte, r_umode, r_esc_char);
                end
            end
            PH_OCT: begin
                if (r_digits == 2'd1) begin
                    n_partial = {8'h00, r_partial[7:0] + {i_byte[4:0] - CH_ZERO[4:0], 3'b000}};
                    n_digits  = 2'd2;
                end else begin
                    n_phase   = PH_IDLE;
                    n_digits  = 2'd0;
                    n_partial = '0;
                    has_cmd   = 1'b1;
                    cmd       = f_finish(oct_val, r_letter, r_umode, r_esc_char);
                end
            end
            PH_HEX: begin
                if (r_digits == 2'd0) begin
                    n_pending = i_byte;
                    n_digits  = 2'd1;
                end else begin
                    n_phase  = PH_IDLE;
                    n_digits = 2'd0;
                    has_cmd  = 1'b1;
                    cmd      = f_finish(pair_val, r_letter, r_umode, r_esc_char);
                end
            end
            PH_UNI: begin
                if (r_digits == 2'd0 || r_digits == 2'd2) begin
                    n_pending = i_byte;
                    n_digits  = r_digits + 2'd1;
                end else if (r_digits == 2'd1) begin
                    n_partial = {pair_val, 8'h00};
                    n_digits  = 2'd2;
                end else begin
                    n_phase   = PH_IDLE;
                    n_digits  = 2'd0;
                    n_partial = '0;
                    has_cmd   = 1'b1;
                    cmd       = f_utf8({r_partial[15:8], pair_val});
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_byte == r_eol_char) begin
                    has_cmd = 1'b1;
                    cmd.cnt = 2'd1;
                    cmd.eol = 1'b1;
                end else if (i_byte == r_esc_char) begin
                    n_phase = PH_ESC;
                end else if (r_umode) begin
                    has_cmd = 1'b1;
                    cmd     = f_utf8({8'h00, i_byte});
                end else begin
                    has_cmd = 1'b1;
                    cmd     = f_single(i_byte);
                end
            end
        endcase
    end

    // parser state, advanced on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_letter  <= '0;
            r_pending <= '0;
            r_partial <= '0;
            r_digits  <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_letter  <= n_letter;
            r_pending <= n_pending;
            r_partial <= n_partial;
            r_digits  <= n_digits;
        end
    end

    assign o_push = accept && has_cmd;
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

// ----- src/eld_queue.sv -----
// ----------------------------------------------------------------------------
// eld_queue
// Small command queue between the parser front and the output back end.
// ----------------------------------------------------------------------------
`default_nettype none

module eld_queue
    import eld_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_room,
    input  wire t_pop i_pop,
    output t_head     o_head
);

    t_cmd                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCOUNT_W-1:0] r_count;

    logic do_pop;

    assign do_pop = i_pop.pop && (r_count != '0);
    assign o_room = (r_count != QCOUNT_W'(QDEPTH));

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.not_empty = (r_count != '0);
    assign o_head.head      = r_mem[r_rd];

endmodule

`default_nettype wire

// ----- src/eld_back.sv -----
// ----------------------------------------------------------------------------
// eld_back
// Sends the bytes of the head command one output transfer at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module eld_back
    import eld_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_head i_head,
    output t_pop       o_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [7:0] o_data,
    output logic [1:0] o_user,
    output logic       o_last
);

    logic [1:0] r_idx;
    logic       xfer;

    assign o_valid = i_head.not_empty;
    assign xfer    = o_valid && i_ready;
    assign o_last  = (r_idx == i_head.head.cnt - 2'd1);
    assign o_user  = {i_head.head.err, i_head.head.eol};

    // byte select within the command
    always_comb begin
        case (r_idx)
            2'd0:    o_data = i_head.head.b0;
            2'd1:    o_data = i_head.head.b1;
            default: o_data = i_head.head.b2;
        endcase
    end

    // byte index, back to zero when the command is done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (xfer) begin
            if (o_last) begin
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_pop.pop = xfer && o_last;

endmodule

`default_nettype wire

// ----- src/eld_checker.sv -----
// ----------------------------------------------------------------------------
// eld_checker
// Port-level checks of the escaped line decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module eld_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic [1:0] o_m_tuser,
    input wire logic       o_m_tlast
);

    // nothing to send right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid right after reset");

    // end of line and error are single, zero-data, last results
    a_flag_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[0] || o_m_tuser[1])) |-> (o_m_tlast && o_m_tdata == 8'd0))
        else $error("flagged result not single");

    // a result is never both end of line and error
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("both flags set");

    // rest of a multi-byte result follows at once
    a_burst_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("multi-byte result broken");

    // stalled output holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled output changed");

endmodule

bind escaped_line_decoder_core eld_checker u_eld_checker (.*);

`default_nettype wire

// ----- tb/escaped_line_decoder_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_line_decoder_core_tb
// Self-checking bench for the escaped line decoder. Raw bytes are streamed in
// with bursty timing while the output side stalls on its own pattern. Every
// accepted byte runs through a cycle-free decoder model kept here, and each
// output transfer is compared against the oldest predicted byte. A short
// directed run hits escape corner cases, and random phases then cover
// well-formed escapes, noise and several register settings.
// ----------------------------------------------------------------------------

module escaped_line_decoder_core_tb;
    import eld_pkg::*;

    localparam int LIMIT      = 200000;
    localparam int SETTLE     = 8;
    localparam int PRINT_CAP  = 50;
    localparam int PHASE_ITEMS = 30;

    // output side stall patterns
    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_MASK,
        RX_CHOKE
    } t_rx_pace;

    // one decoded output transfer
    typedef struct packed {
        logic [7:0] data;
        logic       eol;
        logic       err;
        logic       last;
    } t_dec_out;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_idx  = CFG_UNICODE_MODE;
    logic [7:0] i_cfg_data = 8'h00;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] in_byte
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;            // [7:0] out_byte
    logic [1:0] o_m_tuser;            // [0] end_of_line, [1] escape_error
    logic       o_m_tlast;

    escaped_line_decoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // stimulus and expectation stores
    logic [7:0] raw_q[$];
    t_dec_out   decoded_q[$];
    int         raw_pushed = 0;
    int         raw_taken  = 0;
    int         err_cnt    = 0;
    int         cyc        = 0;

    // register copies
    logic       uni_mode = 1'b0;
    logic [7:0] eol_char = LINE_END_RESET;
    logic [7:0] esc_char = ESCAPE_RESET;

    // decoder state copy
    t_phase     ph         = PH_IDLE;
    logic [7:0] esc_letter = 8'h00;
    logic [7:0] held_digit = 8'h00;
    logic [15:0] acc       = 16'h0000;
    logic [2:0] ndig       = 3'd0;
    t_dec_out   step_buf[3];
    int         step_n;

    // pacing knobs
    bit         tx_gaps    = 1'b1;
    t_rx_pace   rx_mode    = RX_FREE;
    logic [7:0] rx_mask    = 8'hFF;
    int         burst_left = 4;
    int         gap_left   = 0;
    int         bursts     = 0;
    bit         drain_wait = 1'b0;
    logic       in_took    = 1'b0;

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // nibble value of a hex character, wraps on anything else
    function automatic logic [7:0] nib_value(input logic [7:0] c);
        logic [7:0] x;
        logic       alpha;
        x = c;
        if (x >= "A" && x <= "Z") begin
            x = x + 8'd32;
        end
        alpha = (x >= "a" && x <= "z");
        x = x - 8'd48;
        if (alpha) begin
            x = x - 8'd39;
        end
        return x;
    endfunction

    function automatic logic [7:0] byte_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        h = nib_value(hi);
        return (h << 4) + nib_value(lo);
    endfunction

    // control letter value, the letter itself if not a known one
    function automatic logic [7:0] letter_code(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            "a":     v = 8'd7;
            "b":     v = 8'd8;
            "f":     v = 8'd12;
            "n":     v = 8'd10;
            "r":     v = 8'd13;
            "t":     v = 8'd9;
            "v":     v = 8'd11;
            default: v = c;
        endcase
        return v;
    endfunction

    task automatic put_res(input logic [7:0] d, input logic eol, input logic err);
        t_dec_out r;
        r.data = d;
        r.eol  = eol;
        r.err  = err;
        r.last = 1'b0;
        step_buf[step_n] = r;
        step_n++;
    endtask

    task automatic put_utf8(input logic [15:0] v);
        if (v < 16'h0080) begin
            put_res(v[7:0], 1'b0, 1'b0);
        end else if (v < 16'h0800) begin
            put_res({3'b110, v[10:6]}, 1'b0, 1'b0);
            put_res({2'b10, v[5:0]}, 1'b0, 1'b0);
        end else begin
            put_res({4'b1110, v[15:12]}, 1'b0, 1'b0);
            put_res({2'b10, v[11:6]}, 1'b0, 1'b0);
            put_res({2'b10, v[5:0]}, 1'b0, 1'b0);
        end
    endtask

    // end of an escape: error, utf-8, literal pair or single byte
    task automatic close_escape(input logic [7:0] v, input logic [7:0] ltr);
        if (uni_mode) begin
            if (v == ltr) begin
                put_res(8'h00, 1'b0, 1'b1);
            end else begin
                put_utf8({8'h00, v});
            end
        end else if (v == ltr) begin
            put_res(esc_char, 1'b0, 1'b0);
            put_res(ltr, 1'b0, 1'b0);
        end else begin
            put_res(v, 1'b0, 1'b0);
        end
    endtask

    // advance the decoder copy by one byte and queue what it yields
    task automatic decode_byte(input logic [7:0] b);
        logic [7:0] v;
        logic [7:0] t;
        t_dec_out   r;
        step_n = 0;
        case (ph)
            PH_ESC: begin
                esc_letter = b;
                acc        = 16'h0000;
                ndig       = 3'd0;
                held_digit = 8'h00;
                ph         = PH_IDLE;
                if (uni_mode && b == CH_U) begin
                    ph = PH_UNI;
                end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
                    t    = b - CH_ZERO;
                    t    = t << 6;
                    acc  = {8'h00, t};
                    ndig = 3'd1;
                    ph   = PH_OCT;
                end else if (b == CH_X) begin
                    ph = PH_HEX;
                end else begin
                    close_escape(letter_code(b), b);
                end
            end
            PH_OCT: begin
                t = b - CH_ZERO;
                if (ndig == 3'd1) begin
                    t    = t << 3;
                    acc  = {8'h00, acc[7:0] + t};
                    ndig = 3'd2;
                end else begin
                    v    = acc[7:0] + t;
                    ph   = PH_IDLE;
                    ndig = 3'd0;
                    acc  = 16'h0000;
                    close_escape(v, esc_letter);
                end
            end
            PH_HEX: begin
                if (ndig == 3'd0) begin
                    held_digit = b;
                    ndig       = 3'd1;
                end else begin
                    v    = byte_pair(held_digit, b);
                    ph   = PH_IDLE;
                    ndig = 3'd0;
                    close_escape(v, esc_letter);
                end
            end
            PH_UNI: begin
                if (ndig == 3'd0 || ndig == 3'd2) begin
                    held_digit = b;
                    ndig       = ndig + 3'd1;
                end else if (ndig == 3'd1) begin
                    acc  = {byte_pair(held_digit, b), 8'h00};
                    ndig = 3'd2;
                end else begin
                    v    = byte_pair(held_digit, b);
                    ph   = PH_IDLE;
                    ndig = 3'd0;
                    put_utf8({acc[15:8], v});
                    acc  = 16'h0000;
                end
            end
            default: begin
                ph = PH_IDLE;
                if (b == eol_char) begin
                    put_res(8'h00, 1'b1, 1'b0);
                end else if (b == esc_char) begin
                    ph = PH_ESC;
                end else if (uni_mode) begin
                    put_utf8({8'h00, b});
                end else begin
                    put_res(b, 1'b0, 1'b0);
                end
            end
        endcase
        for (int i = 0; i < step_n; i++) begin
            r      = step_buf[i];
            r.last = (i == step_n - 1);
            decoded_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        if (err_cnt < PRINT_CAP) begin
            $display("mismatch %s: expected %0h got %0h at cycle %0d", what, want_v, got_v, cyc);
        end
        err_cnt++;
    endtask

    task automatic check_output;
        t_dec_out want;
        if (decoded_q.size() == 0) begin
            report_mismatch("output with nothing pending", 0, o_m_tdata);
        end else begin
            want = decoded_q.pop_front();
            if (o_m_tuser[0] !== want.eol) begin
                report_mismatch("end_of_line", want.eol, o_m_tuser[0]);
            end
            if (o_m_tuser[1] !== want.err) begin
                report_mismatch("escape_error", want.err, o_m_tuser[1]);
            end
            if (o_m_tlast !== want.last) begin
                report_mismatch("last", want.last, o_m_tlast);
            end
            // data carries no meaning on end or error transfers
            if (!want.eol && !want.err && o_m_tdata !== want.data) begin
                report_mismatch("out_byte", want.data, o_m_tdata);
            end
        end
    endtask

    // monitor: output check, then prediction of the input transfer
    always @(posedge i_clk) begin
        cyc++;
        in_took <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                check_output();
            end
            if (i_s_tvalid && o_s_tready) begin
                decode_byte(i_s_tdata);
                raw_taken++;
            end
        end
        if (cyc >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // input driver: bursts, gaps and an occasional full drain
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !in_took) begin
            // transfer still pending, hold
        end else if (drain_wait) begin
            i_s_tvalid <= 1'b0;
            if (decoded_q.size() == 0) begin
                drain_wait = 1'b0;
            end
        end else if (gap_left > 0) begin
            i_s_tvalid <= 1'b0;
            gap_left--;
        end else if (raw_q.size() == 0) begin
            i_s_tvalid <= 1'b0;
        end else begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= raw_q.pop_front();
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                bursts++;
                if (tx_gaps) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20)
                                                           : $urandom_range(1, 4);
                    if (bursts % 5 == 0) begin
                        drain_wait = 1'b1;
                    end
                end
            end
        end
    end

    // output side stall pattern
    always @(negedge i_clk) begin
        case (rx_mode)
            RX_FREE:   i_m_tready <= 1'b1;
            RX_RANDOM: i_m_tready <= ($urandom_range(0, 3) != 0);
            RX_MASK:   i_m_tready <= rx_mask[cyc[2:0]];
            default:   i_m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic push_raw(input logic [7:0] b);
        raw_q.push_back(b);
        raw_pushed++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_raw(s[i]);
        end
    endtask

    // wait for all transfers and results, then let the block settle
    task automatic wait_drained;
        do begin
            @(negedge i_clk);
        end while (raw_q.size() != 0 || raw_taken != raw_pushed || decoded_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_UNICODE_MODE:  uni_mode = val[0];
            CFG_LINE_END_CHAR: eol_char = val;
            CFG_ESCAPE_CHAR:   esc_char = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic m, input logic [7:0] le, input logic [7:0] ec);
        write_reg(CFG_UNICODE_MODE, {7'd0, m});
        write_reg(CFG_LINE_END_CHAR, le);
        write_reg(CFG_ESCAPE_CHAR, ec);
    endtask

    task automatic set_pace(input bit gaps, input t_rx_pace rmode);
        tx_gaps = gaps;
        rx_mode = rmode;
        rx_mask = 8'($urandom_range(1, 255));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10) begin
            return CH_ZERO + n;
        end
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + n - 8'd10;
    endfunction

    // mostly hex or octal digits, sometimes any byte
    function automatic logic [7:0] digit_or_noise(input logic [7:0] good);
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : good;
    endfunction

    // well-formed escapes with random content, mixed with noise
    task automatic gen_random(input int count);
        int          added;
        int          r;
        logic [15:0] cp;
        string       letters;
        letters = "abfnrtvxu";
        added   = 0;
        while (added < count) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                push_raw(8'($urandom_range(0, 255)));
                added += 1;
            end else if (r < 35) begin
                push_raw(8'($urandom_range(0, 255)));
                added += 1;
            end else if (r < 43) begin
                push_raw(eol_char);
                added += 1;
            end else if (r < 58) begin
                push_raw(esc_char);
                case ($urandom_range(0, 3))
                    0:       push_raw(esc_char);
                    1:       push_raw(8'($urandom_range(0, 255)));
                    default: push_raw(letters[$urandom_range(0, 6)]);
                endcase
                added += 2;
            end else if (r < 71) begin
                push_raw(esc_char);
                for (int i = 0; i < 3; i++) begin
                    push_raw(digit_or_noise(CH_ZERO + 8'($urandom_range(0, 7))));
                end
                added += 4;
            end else if (r < 84) begin
                push_raw(esc_char);
                push_raw(CH_X);
                for (int i = 0; i < 2; i++) begin
                    push_raw(digit_or_noise(hex_char(4'($urandom_range(0, 15)))));
                end
                added += 4;
            end else begin
                // code points spread over the one, two and three byte forms
                case ($urandom_range(0, 2))
                    0:       cp = 16'($urandom_range(0, 16'h007F));
                    1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                push_raw(esc_char);
                push_raw(CH_U);
                for (int i = 3; i >= 0; i--) begin
                    push_raw(digit_or_noise(hex_char(cp[i*4 +: 4])));
                end
                added += 6;
            end
        end
    endtask

    // reset, directed cases, random phases, final verdict
    initial begin
        logic [7:0] pick;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte mode on reset values: extremes, literal pairs, octal and hex equal to letter
        set_pace(1'b1, RX_RANDOM);
        push_raw(8'h00);
        push_raw(8'hFF);
        push_str("\\q\\060\\x78\\u");
        push_raw(LINE_END_RESET);
        wait_drained();

        // unicode mode: max code point, unknown escape, mode switch mid-escape
        set_config(1'b1, LINE_END_RESET, ESCAPE_RESET);
        set_pace(1'b0, RX_FREE);
        push_str("\\uFFFF\\q\\x4");
        wait_drained();
        write_reg(CFG_UNICODE_MODE, 8'h00);
        push_str("1");
        wait_drained();

        // terminator equal to the escape byte
        set_config(1'b0, 8'h5C, 8'h5C);
        set_pace(1'b1, RX_CHOKE);
        push_str("a\\b");

        for (int k = 0; k < 9; k++) begin
            wait_drained();
            pick = 8'($urandom_range(0, 255));
            case (k)
                0:       set_config(1'b0, LINE_END_RESET, ESCAPE_RESET);
                1:       set_config(1'b1, LINE_END_RESET, ESCAPE_RESET);
                2:       set_config(1'b0, 8'h00, 8'hFF);
                3:       set_config(1'b1, 8'hFF, 8'h00);
                4:       set_config(1'b1, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
                5:       set_config(1'b0, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
                6:       set_config(1'($urandom_range(0, 1)), pick, pick);
                default: set_config(1'($urandom_range(0, 1)), LINE_END_RESET, ESCAPE_RESET);
            endcase
            set_pace(k % 3 != 2, t_rx_pace'(k % 4));
            gen_random(PHASE_ITEMS);
        end

        wait_drained();
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
